>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// General property, checked on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/vsep_pkg.sv
`timescale 1ns / 1ps

package vsep_pkg;

   // Command codes.
   localparam logic CMD_SCATTER = 1'b0;
   localparam logic CMD_READ    = 1'b1;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MODE_MIN    = 3'd0;
   localparam logic [2:0] CSR_CHANNELS    = 3'd1;
   localparam logic [2:0] CSR_GRID_SIZE_X = 3'd2;
   localparam logic [2:0] CSR_GRID_SIZE_Y = 3'd3;
   localparam logic [2:0] CSR_GRID_SIZE_Z = 3'd4;
   localparam logic [2:0] CSR_SCALE_X     = 3'd5;
   localparam logic [2:0] CSR_SCALE_Y     = 3'd6;
   localparam logic [2:0] CSR_SCALE_Z     = 3'd7;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [23:0] SCALE_ONE = 24'h010000;

   typedef struct packed {
      logic               cmd;
      logic        [3:0]  batch_index;
      logic        [5:0]  channel_index;
      logic signed [23:0] coord_x;
      logic signed [23:0] coord_y;
      logic signed [23:0] coord_z;
      logic signed [31:0] feature;
      logic        [15:0] read_address;
   } req_type;

   typedef struct packed {
      logic               in_range;
      logic               updated;
      logic signed [31:0] voxel_value;
      logic               voxel_touched;
   } rsp_type;

   typedef struct packed {
      logic              mode_min;
      logic [6:0]        channels_in_use;
      logic [2:0][10:0]  grid_size;
      logic [2:0][23:0]  scale;
   } cfg_type;

   // Status from the address generator to the controller.
   typedef struct packed {
      logic done;
      logic ok;
   } ag_status_type;

endpackage

>>> sv/vsep_ram.sv
`timescale 1ns / 1ps

module vsep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/vsep_addr_gen.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vsep_addr_gen import vsep_pkg::*; #(
   parameter int BATCH       = 2,
   parameter int DIMS        = 3,
   parameter int VOXEL_DEPTH = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  req_type                        req_item,
   input  cfg_type                        cfg,
   output ag_status_type                  status,
   output logic [$clog2(VOXEL_DEPTH)-1:0] addr
);

   localparam int AW  = $clog2(VOXEL_DEPTH);
   localparam int SW  = AW + 12;
   localparam int SCW = (DIMS > 1) ? $clog2(DIMS) : 1;

   logic [2:0][23:0]      coord_all;
   logic [DIMS-1:0][10:0] axis_idx;
   logic [DIMS-1:0]       axis_ok;
   logic [11:0]           base;
   logic                  base_ok;
   logic                  base_over;
   logic [SW-1:0]         sum;
   logic                  sum_over;

   logic [DIMS-1:0][10:0] idx_ff, idx_in;
   logic [DIMS-1:0]       axis_ok_ff, axis_ok_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic                  over_ff, over_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [SCW-1:0]        step_ff, step_in;

   assign coord_all = {req_item.coord_z, req_item.coord_y, req_item.coord_x};

   // Each axis: |coord| * scale, keep the integer part, then range check. A
   // negative product that truncates to zero still lands on index zero.
   for (genvar d = 0; d < DIMS; d++) begin : g_axis
      logic        neg;
      logic [23:0] mag;
      logic [47:0] prod;
      logic [23:0] q;
      assign neg  = coord_all[d][23];
      assign mag  = neg ? (~coord_all[d] + 24'd1) : coord_all[d];
      assign prod = 48'(mag) * 48'(cfg.scale[d]);
      assign q    = prod[47:24];
      assign axis_idx[d] = q[10:0];
      assign axis_ok[d]  = !(neg && (q != 24'd0)) && (q < 24'(cfg.grid_size[d]));
   end

   assign base = 12'(req_item.batch_index) * 12'(cfg.channels_in_use)
               + 12'(req_item.channel_index);
   assign base_ok = (5'(req_item.batch_index) < 5'(BATCH))
                 && ({1'b0, req_item.channel_index} < cfg.channels_in_use);
   assign base_over = SW'(base) >= SW'(VOXEL_DEPTH);

   // One multiply-add per axis. The running address never needs more than AW
   // bits: once a partial result reaches the depth the point is out anyway.
   assign sum = SW'(acc_ff) * SW'(cfg.grid_size[step_ff]) + SW'(idx_ff[step_ff]);
   assign sum_over = sum >= SW'(VOXEL_DEPTH);

   always_comb begin
      idx_in     = idx_ff;
      axis_ok_in = axis_ok_ff;
      acc_in     = acc_ff;
      over_in    = over_ff;
      run_in     = run_ff;
      step_in    = step_ff;
      done_in    = 1'b0;
      if (start) begin
         idx_in     = axis_idx;
         axis_ok_in = axis_ok;
         acc_in     = AW'(base);
         over_in    = !base_ok || base_over;
         run_in     = 1'b1;
         step_in    = '0;
      end else if (run_ff) begin
         acc_in  = AW'(sum);
         over_in = over_ff || !axis_ok_ff[step_ff] || sum_over;
         if (step_ff == SCW'(DIMS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + SCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      idx_ff     <= idx_in;
      axis_ok_ff <= axis_ok_in;
      acc_ff     <= acc_in;
      over_ff    <= over_in;
   end

   assign status.done = done_ff;
   assign status.ok   = !over_ff;
   assign addr        = acc_ff;

   `ASSERT_PROP(a_done_pulse, clock, reset, done_ff |=> !done_ff, "done held longer than one cycle")
   `ASSERT_PROP(a_no_restart, clock, reset, start |-> !run_ff, "start while address walk runs")
   `ASSERT_IMPLY(a_done_ends_walk, clock, reset, done_ff, !run_ff, "done while address walk runs")

endmodule

>>> sv/voxel_scatter_extremum_pool.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Ports                          Handshake
// request  start, busy, req_item          beat taken when start is high and busy low
// result   rsp_valid, rsp_item            one-cycle strobe, no back-pressure
// config   csr_we, csr_index, csr_wdata   register written when csr_we is high
//
// After reset the touched marks are cleared by a pass over all VOXEL_DEPTH entries
// with busy high; configuration writes are taken during that pass.
// A scatter runs in steps: the accept cycle runs the coordinate multipliers, the
// address walk runs the shared multiply-add once per axis, the address is handed
// over, the voxel memories are read, and the result is compared and written back.
// Busy stays high until the write-back ends.
// A read skips the address walk; an invalid read is answered from idle and a
// dropped point ends with the walk. The receiver cannot stall the block.
// The result strobe rises the cycle after the work ends, while the next
// request beat may already be taken.

module voxel_scatter_extremum_pool import vsep_pkg::*; #(
   parameter int BATCH       = 2,
   parameter int DIMS        = 3,
   parameter int VOXEL_DEPTH = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_item,
   output logic                   rsp_valid,
   output rsp_type                rsp_item,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = $clog2(VOXEL_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(VOXEL_DEPTH - 1);

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_MAP    = 5'b00100,
      S_READ   = 5'b01000,
      S_UPDATE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   cfg_type            cfg_ff, cfg_in;
   logic [AW-1:0]      clr_cnt_ff, clr_cnt_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic               cmd_ff, cmd_in;
   logic signed [31:0] feature_ff, feature_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   ag_status_type      ag_status;
   logic [AW-1:0]      ag_addr;
   logic               ag_start;

   logic               store_we;
   logic [31:0]        store_rd;
   logic               mark_we;
   logic [AW-1:0]      mark_waddr;
   logic               mark_wdata;
   logic               mark_rd;
   logic               read_ok;
   logic               upd;

   vsep_addr_gen #(
      .BATCH       (BATCH),
      .DIMS        (DIMS),
      .VOXEL_DEPTH (VOXEL_DEPTH)
   ) u_addr_gen (
      .clock    (clock),
      .reset    (reset),
      .start    (ag_start),
      .req_item (req_item),
      .cfg      (cfg_ff),
      .status   (ag_status),
      .addr     (ag_addr)
   );

   vsep_ram #(
      .WIDTH (32),
      .DEPTH (VOXEL_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (addr_ff),
      .wr_data (feature_ff),
      .rd_addr (addr_ff),
      .rd_data (store_rd)
   );

   vsep_ram #(
      .WIDTH (1),
      .DEPTH (VOXEL_DEPTH)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_we),
      .wr_addr (mark_waddr),
      .wr_data (mark_wdata),
      .rd_addr (addr_ff),
      .rd_data (mark_rd)
   );

   // Configuration decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE_MIN:    cfg_in.mode_min        = csr_wdata[0];
            CSR_CHANNELS:    cfg_in.channels_in_use = csr_wdata[6:0];
            CSR_GRID_SIZE_X: cfg_in.grid_size[0]    = csr_wdata[10:0];
            CSR_GRID_SIZE_Y: cfg_in.grid_size[1]    = csr_wdata[10:0];
            CSR_GRID_SIZE_Z: cfg_in.grid_size[2]    = csr_wdata[10:0];
            CSR_SCALE_X:     cfg_in.scale[0]        = csr_wdata;
            CSR_SCALE_Y:     cfg_in.scale[1]        = csr_wdata;
            CSR_SCALE_Z:     cfg_in.scale[2]        = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   assign read_ok = 32'(req_item.read_address) < 32'(VOXEL_DEPTH);

   // A first touch always writes; otherwise strict signed compare by mode.
   assign upd = !mark_rd
             || (cfg_ff.mode_min ? (feature_ff < $signed(store_rd))
                                 : (feature_ff > $signed(store_rd)));

   // Only one item is in flight, and its write-back ends before the next read
   // is issued, so no read whose data is used overlaps a write to one entry.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      feature_in   = feature_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ag_start     = 1'b0;
      store_we     = 1'b0;
      mark_we      = 1'b0;
      mark_wdata   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            mark_we    = 1'b1;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in     = req_item.cmd;
               feature_in = req_item.feature;
               if (req_item.cmd == CMD_READ) begin
                  if (read_ok) begin
                     addr_in  = AW'(req_item.read_address);
                     state_in = S_READ;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
               end else begin
                  ag_start = 1'b1;
                  state_in = S_MAP;
               end
            end
         end
         S_MAP: begin
            if (ag_status.done) begin
               if (ag_status.ok) begin
                  addr_in  = ag_addr;
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  state_in     = S_IDLE;
               end
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            mark_we              = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_in.in_range      = 1'b1;
            if (cmd_ff == CMD_READ) begin
               mark_wdata           = 1'b0;
               rsp_in.updated       = 1'b0;
               rsp_in.voxel_value   = store_rd;
               rsp_in.voxel_touched = mark_rd;
            end else begin
               mark_wdata           = 1'b1;
               store_we             = upd;
               rsp_in.updated       = upd;
               rsp_in.voxel_value   = upd ? feature_ff : store_rd;
               rsp_in.voxel_touched = 1'b1;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   assign mark_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                <= S_CLEAR;
         clr_cnt_ff              <= '0;
         rsp_valid_ff            <= 1'b0;
         cfg_ff.mode_min         <= 1'b0;
         cfg_ff.channels_in_use  <= 7'd1;
         cfg_ff.grid_size        <= {3{11'd1}};
         cfg_ff.scale            <= {3{SCALE_ONE}};
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      addr_ff    <= addr_in;
      cmd_ff     <= cmd_in;
      feature_ff <= feature_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `ASSERT_PROP(a_update_responds, clock, reset, (state_ff == S_UPDATE) |=> rsp_valid, "no beat after update")
   `ASSERT_PROP(a_updated_touched, clock, reset, (rsp_valid && rsp_item.updated) |-> (rsp_item.voxel_touched && rsp_item.in_range), "updated beat without touch")
   `ASSERT_PROP(a_clear_writes_zero, clock, reset, (state_ff == S_CLEAR) |-> (mark_we && !mark_wdata && !store_we && !rsp_valid_in), "clear pass disturbed")

endmodule

>>> sim/voxel_scatter_extremum_pool_tb.sv
`timescale 1ns / 1ps

module voxel_scatter_extremum_pool_tb;
   import vsep_pkg::*;

   localparam int BATCH        = 2;
   localparam int DIMS         = 3;
   localparam int VOXEL_DEPTH  = 65536;
   localparam int LIMIT_CYCLES = 400000;
   localparam int SETTLE       = 12;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_item;
   logic                   rsp_valid;
   rsp_type                rsp_item;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   voxel_scatter_extremum_pool #(
      .BATCH(BATCH),
      .DIMS(DIMS),
      .VOXEL_DEPTH(VOXEL_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Mirror of the block's registers and voxel memories.
   logic               mirror_mode_min;
   logic [6:0]         mirror_channels;
   logic [10:0]        mirror_grid [3];
   logic [23:0]        mirror_scale [3];
   logic signed [31:0] voxel_mem [VOXEL_DEPTH];
   bit                 voxel_mark [VOXEL_DEPTH];
   bit                 voxel_written [VOXEL_DEPTH];
   int                 written_addrs [$];

   rsp_type pool_outcomes [$];

   int sender_idle_pct = 0;
   int mismatches      = 0;
   int cycle_count     = 0;
   int results_seen    = 0;
   int points_in_grid  = 0;
   int points_dropped  = 0;
   int points_updated  = 0;
   int reads_done      = 0;
   int reads_touched   = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Expected outcome of one accepted beat; updates the mirror state.
   function automatic rsp_type pool_apply(input req_type r);
      rsp_type            o;
      logic signed [23:0] crd [3];
      longint             addr;
      longint             mag;
      longint             q;
      logic signed [31:0] feat;
      bit                 upd;
      o = '0;
      if (r.cmd == CMD_READ) begin
         o.in_range      = 1'b1;
         o.voxel_value   = voxel_mem[r.read_address];
         o.voxel_touched = voxel_mark[r.read_address];
         voxel_mark[r.read_address] = 1'b0;
         reads_done++;
         if (o.voxel_touched) reads_touched++;
         return o;
      end
      crd[0] = r.coord_x;
      crd[1] = r.coord_y;
      crd[2] = r.coord_z;
      points_dropped++;
      if (int'(r.batch_index) >= BATCH || r.channel_index >= mirror_channels) return o;
      addr = longint'(r.batch_index) * longint'(mirror_channels) + longint'(r.channel_index);
      for (int d = 0; d < DIMS; d++) begin
         mag = longint'(crd[d]);
         if (mag < 0) mag = -mag;
         q = (mag * longint'(mirror_scale[d])) >> 24;
         // A small negative coordinate truncates to index zero and stays in range.
         if (crd[d] < 0 && q != 0) return o;
         if (q >= longint'(mirror_grid[d])) return o;
         addr = addr * longint'(mirror_grid[d]) + q;
      end
      if (addr >= VOXEL_DEPTH) return o;
      points_dropped--;
      points_in_grid++;
      feat = $signed(r.feature);
      if (!voxel_mark[addr]) upd = 1'b1;
      else if (mirror_mode_min) upd = feat < voxel_mem[addr];
      else upd = feat > voxel_mem[addr];
      if (upd) begin
         voxel_mem[addr] = feat;
         points_updated++;
         if (!voxel_written[addr]) begin
            voxel_written[addr] = 1'b1;
            written_addrs.push_back(int'(addr));
         end
      end
      voxel_mark[addr] = 1'b1;
      o.in_range      = 1'b1;
      o.updated       = upd;
      o.voxel_value   = voxel_mem[addr];
      o.voxel_touched = 1'b1;
      return o;
   endfunction

   // Every result strobe is checked against the oldest outstanding outcome.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (pool_outcomes.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing outstanding: %0h", rsp_item));
         end else begin
            want = pool_outcomes.pop_front();
            if (rsp_item.in_range !== want.in_range)
               report_mismatch($sformatf("in_range got %b want %b",
                                         rsp_item.in_range, want.in_range));
            if (rsp_item.updated !== want.updated)
               report_mismatch($sformatf("updated got %b want %b",
                                         rsp_item.updated, want.updated));
            if (rsp_item.voxel_value !== want.voxel_value)
               report_mismatch($sformatf("voxel_value got %h want %h",
                                         rsp_item.voxel_value, want.voxel_value));
            if (rsp_item.voxel_touched !== want.voxel_touched)
               report_mismatch($sformatf("voxel_touched got %b want %b",
                                         rsp_item.voxel_touched, want.voxel_touched));
         end
      end
   end

   // Writes all eight registers on consecutive cycles; bits above each
   // register's width carry junk that the block must ignore.
   task automatic apply_settings(input logic mode, input int chans, input int gx,
                                 input int gy, input int gz, input int sx,
                                 input int sy, input int sz);
      logic [2:0]  codes [8];
      int          widths [8];
      logic [23:0] vals [8];
      logic [23:0] junk;
      codes  = '{CSR_MODE_MIN, CSR_CHANNELS, CSR_GRID_SIZE_X, CSR_GRID_SIZE_Y,
                 CSR_GRID_SIZE_Z, CSR_SCALE_X, CSR_SCALE_Y, CSR_SCALE_Z};
      widths = '{1, 7, 11, 11, 11, 24, 24, 24};
      vals   = '{24'(mode), 24'(chans), 24'(gx), 24'(gy), 24'(gz),
                 24'(sx), 24'(sy), 24'(sz)};
      for (int i = 0; i < 8; i++) begin
         vals[i] = vals[i] & ((24'hFFFFFF) >> (24 - widths[i]));
         junk = $urandom;
         csr_we    <= 1'b1;
         csr_index <= codes[i];
         csr_wdata <= vals[i] | (junk << widths[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      mirror_mode_min = vals[0][0];
      mirror_channels = vals[1][6:0];
      for (int d = 0; d < 3; d++) begin
         mirror_grid[d]  = vals[2 + d][10:0];
         mirror_scale[d] = vals[5 + d];
      end
   endtask

   task automatic send_beat(input req_type r);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy !== 1'b0);
      pool_outcomes.push_back(pool_apply(r));
   endtask

   // Lowers start and waits until every outstanding result has come back.
   task automatic drain_outcomes();
      start <= 1'b0;
      while (pool_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic req_type point_beat(input int b, input int ch, input logic [23:0] x,
                                          input logic [23:0] y, input logic [23:0] z,
                                          input logic [31:0] feat);
      req_type r;
      r.cmd           = CMD_SCATTER;
      r.batch_index   = 4'(b);
      r.channel_index = 6'(ch);
      r.coord_x       = x;
      r.coord_y       = y;
      r.coord_z       = z;
      r.feature       = feat;
      r.read_address  = 16'($urandom);
      return r;
   endfunction

   function automatic req_type read_beat(input int addr);
      req_type r;
      r.cmd           = CMD_READ;
      r.batch_index   = 4'($urandom);
      r.channel_index = 6'($urandom);
      r.coord_x       = 24'($urandom);
      r.coord_y       = 24'($urandom);
      r.coord_z       = 24'($urandom);
      r.feature       = $urandom;
      r.read_address  = 16'(addr);
      return r;
   endfunction

   // Mostly low indexes so that points pile up on the same voxels; now and
   // then exactly one past the limit.
   function automatic int pick_index(input int limit);
      if (limit == 0) return 0;
      if ($urandom_range(0, 19) == 0) return limit;
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, limit < 4 ? limit - 1 : 3);
      return $urandom_range(0, limit - 1);
   endfunction

   // A coordinate that lands on voxel index idx under the given scale.
   function automatic logic [23:0] coord_for(input int idx, input logic [23:0] scale);
      longint lo;
      longint hi;
      longint v;
      if (scale == 0) return 24'($urandom);
      lo = ((longint'(idx) << 24) + scale - 1) / scale;
      hi = ((longint'(idx + 1) << 24) + scale - 1) / scale - 1;
      if (lo > 8388607) return 24'h7FFFFF;
      if (hi > 8388607) hi = 8388607;
      if (idx == 0 && $urandom_range(0, 2) == 0) v = -longint'($urandom_range(0, int'(hi)));
      else v = lo + longint'($urandom_range(0, int'(hi - lo)));
      return v[23:0];
   endfunction

   function automatic req_type random_beat();
      req_type r;
      int      roll;
      logic [23:0] xyz [3];
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
         r = read_beat($urandom);
         r.cmd = CMD_READ;
         if ($urandom_range(0, 1) == 0 || written_addrs.size() == 0) r.cmd = CMD_SCATTER;
         else if (!voxel_written[r.read_address])
            r.read_address = 16'(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
         return r;
      end
      if (roll < 40 && written_addrs.size() != 0)
         return read_beat(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
      for (int d = 0; d < 3; d++) xyz[d] = coord_for(pick_index(mirror_grid[d]), mirror_scale[d]);
      r = point_beat(($urandom_range(0, 19) == 0) ? $urandom_range(BATCH, 15)
                                                  : $urandom_range(0, BATCH - 1),
                     pick_index(mirror_channels), xyz[0], xyz[1], xyz[2], $urandom);
      case ($urandom_range(0, 9))
         0: r.feature = 32'h7FFFFFFF;
         1: r.feature = 32'h80000000;
         default: ;
      endcase
      return r;
   endfunction

   task automatic run_random_points(input int count, input int idle, input bit pause_midway);
      sender_idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         if (pause_midway && i == count / 2) drain_outcomes();
         send_beat(random_beat());
      end
      drain_outcomes();
   endtask

   task automatic test_reset_settings();
      sender_idle_pct = 0;
      send_beat(point_beat(0, 0, 24'd0, 24'd0, 24'd0, 32'd100));
      send_beat(point_beat(0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 32'd50));
      send_beat(point_beat(1, 0, 24'd0, 24'd0, 24'd0, 32'h7FFFFFFF));
      send_beat(point_beat(2, 0, 24'd0, 24'd0, 24'd0, 32'd1));
      send_beat(point_beat(0, 1, 24'd0, 24'd0, 24'd0, 32'd1));
      send_beat(point_beat(0, 0, 24'd256, 24'd0, 24'd0, 32'd1));
      send_beat(point_beat(0, 0, 24'd0, -24'sd256, 24'd0, 32'd1));
      send_beat(read_beat(0));
      send_beat(read_beat(0));
      send_beat(point_beat(0, 0, 24'd0, 24'd0, 24'd0, 32'h80000000));
      send_beat(read_beat(1));
      drain_outcomes();
   endtask

   task automatic test_register_extremes();
      apply_settings(1'b1, 64, 2047, 2047, 2047, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      // Equal feature under the minimum mode must not count as an update.
      send_beat(point_beat(0, 0, 24'd0, 24'd0, 24'd0, 32'h80000000));
      send_beat(point_beat(0, 0, 24'h7FFFFF, 24'd0, 24'd0, 32'd3));
      send_beat(point_beat(1, 63, 24'd0, 24'd0, 24'd0, 32'hFFFFFFFF));
      send_beat(point_beat(0, 0, 24'h800000, 24'd0, 24'd0, 32'd3));
      send_beat(read_beat(0));
      drain_outcomes();
      apply_settings(1'b0, 0, 1, 1, 1, SCALE_ONE, SCALE_ONE, SCALE_ONE);
      send_beat(point_beat(0, 0, 24'd0, 24'd0, 24'd0, 32'd9));
      drain_outcomes();
      apply_settings(1'b0, 1, 0, 1, 1, SCALE_ONE, SCALE_ONE, SCALE_ONE);
      send_beat(point_beat(0, 0, 24'd0, 24'd0, 24'd0, 32'd9));
      drain_outcomes();
      // A zero scale maps every coordinate, even the most negative, to index zero.
      apply_settings(1'b1, 1, 1, 1, 1, 0, 0, 0);
      send_beat(point_beat(0, 0, 24'h800000, 24'h7FFFFF, 24'h800000, 32'd5));
      send_beat(point_beat(0, 0, 24'h7FFFFF, 24'h800000, 24'h000001, 32'h7FFFFFFF));
      send_beat(read_beat(0));
      drain_outcomes();
   endtask

   // 2 batches x 64 channels x 8x8x8 voxels cover the whole store.
   task automatic test_max_full_store();
      apply_settings(1'b0, 64, 8, 8, 8, SCALE_ONE, SCALE_ONE, SCALE_ONE);
      run_random_points(200, 0, 1'b0);
   endtask

   task automatic test_min_fractional_scale();
      apply_settings(1'b1, 5, 3, 4, 2, 24'h018000, 24'h00C000, 24'h02A3D7);
      run_random_points(170, 86, 1'b1);
   endtask

   // The grid of batch 1 lies wholly beyond the store, so many points fall off the end.
   task automatic test_wide_grid_partial_store();
      apply_settings(1'b0, 1, 1024, 64, 1, 24'h004000, 24'h020000, SCALE_ONE);
      run_random_points(170, 22, 1'b0);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 4; p++) begin
         apply_settings($urandom_range(0, 1), $urandom_range(1, 64), $urandom_range(1, 16),
                        $urandom_range(1, 16), $urandom_range(1, 16),
                        $urandom_range(16384, 262144), $urandom_range(16384, 262144),
                        $urandom_range(16384, 262144));
         run_random_points(40, (p % 2 == 0) ? 0 : 22, 1'b0);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_item  <= '0;
      csr_we    <= 1'b0;
      csr_index <= CSR_MODE_MIN;
      csr_wdata <= '0;
      mirror_mode_min = 1'b0;
      mirror_channels = 7'd1;
      for (int d = 0; d < 3; d++) begin
         mirror_grid[d]  = 11'd1;
         mirror_scale[d] = SCALE_ONE;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_register_extremes();
      test_max_full_store();
      test_min_fractional_scale();
      test_wide_grid_partial_store();
      test_random_settings();

      repeat (SETTLE) @(posedge clock);
      $display("summary: %0d results checked; %0d points hit the grid (%0d stored), %0d dropped",
               results_seen, points_in_grid, points_updated, points_dropped);
      $display("summary: %0d reads, %0d of them on touched voxels, both modes, %0d mismatches",
               reads_done, reads_touched, mismatches);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/vsep_pkg.sv
sv/vsep_ram.sv
sv/vsep_addr_gen.sv
sv/voxel_scatter_extremum_pool.sv
sim/voxel_scatter_extremum_pool_tb.sv
